// File: design/vpt_pkg.sv
// Shared widths, constants, register codes and types of the velocity PID block.
package vpt_pkg;

   // Field widths
   localparam int SPEED_W    = 16;
   localparam int ERR_W      = 17;
   localparam int GAIN_W     = 16;
   localparam int MAX_W      = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Fixed outputs and thresholds
   localparam logic signed [SPEED_W-1:0] IDLE_OUT           = -16'sd12800;
   localparam logic signed [ERR_W-1:0]   BRAKE_ENTER_MARGIN = 17'sd25;

   // Lower clamps of the two loops
   localparam logic [MAX_W-1:0] TORQUE_FLOOR = 15'd0;
   localparam logic [MAX_W-1:0] BRAKE_FLOOR  = 15'd0;

   // Register reset values
   localparam logic [GAIN_W-1:0] KP_RESET  = 16'd1024;
   localparam logic [GAIN_W-1:0] KI_RESET  = 16'd0;
   localparam logic [GAIN_W-1:0] KD_RESET  = 16'd0;
   localparam logic [MAX_W-1:0]  MAX_RESET = 15'd20480;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TORQUE_KP    = 3'd0,
      REG_TORQUE_KI    = 3'd1,
      REG_TORQUE_KD    = 3'd2,
      REG_TORQUE_LIMIT = 3'd3,
      REG_BRAKE_KP     = 3'd4,
      REG_BRAKE_KI     = 3'd5,
      REG_BRAKE_KD     = 3'd6,
      REG_BRAKE_LIMIT  = 3'd7
   } csr_idx_type;

   // Gains and clamps as seen by the datapath
   typedef struct packed {
      logic [GAIN_W-1:0] torque_kp;
      logic [GAIN_W-1:0] torque_ki;
      logic [GAIN_W-1:0] torque_kd;
      logic [MAX_W-1:0]  torque_limit;
      logic [GAIN_W-1:0] brake_kp;
      logic [GAIN_W-1:0] brake_ki;
      logic [GAIN_W-1:0] brake_kd;
      logic [MAX_W-1:0]  brake_limit;
   } cfg_type;

endpackage

// File: design/vpt_csr.sv
// Configuration register file: gains and output clamps of both loops.
module vpt_csr
   import vpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type               cfg_o
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

   // Decode the written register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            REG_TORQUE_KP:    cfg_in.torque_kp    = csr_data[GAIN_W-1:0];
            REG_TORQUE_KI:    cfg_in.torque_ki    = csr_data[GAIN_W-1:0];
            REG_TORQUE_KD:    cfg_in.torque_kd    = csr_data[GAIN_W-1:0];
            REG_TORQUE_LIMIT: cfg_in.torque_limit = csr_data[MAX_W-1:0];
            REG_BRAKE_KP:     cfg_in.brake_kp     = csr_data[GAIN_W-1:0];
            REG_BRAKE_KI:     cfg_in.brake_ki     = csr_data[GAIN_W-1:0];
            REG_BRAKE_KD:     cfg_in.brake_kd     = csr_data[GAIN_W-1:0];
            REG_BRAKE_LIMIT:  cfg_in.brake_limit  = csr_data[MAX_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.torque_kp    <= KP_RESET;
         cfg_ff.torque_ki    <= KI_RESET;
         cfg_ff.torque_kd    <= KD_RESET;
         cfg_ff.torque_limit <= MAX_RESET;
         cfg_ff.brake_kp     <= KP_RESET;
         cfg_ff.brake_ki     <= KI_RESET;
         cfg_ff.brake_kd     <= KD_RESET;
         cfg_ff.brake_limit  <= MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: design/vpt_pid.sv
// Incremental PID datapath with mode selection and shared loop history.
module vpt_pid
   import vpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_i,
   input  logic signed [SPEED_W-1:0] target_i,
   input  logic signed [SPEED_W-1:0] measured_i,
   input  cfg_type                   cfg_i,
   output logic signed [SPEED_W-1:0] drive_o,
   output logic                      braking_o
);

   localparam int D1_W  = ERR_W + 1;
   localparam int D2_W  = ERR_W + 2;
   localparam int ACC_W = GAIN_W + 1 + D2_W + 2;
   localparam int SCL_W = ACC_W - 8;
   localparam int SUM_W = SCL_W + 1;

   // Only the loop that ran last can hold non-zero history, so one set is kept
   // with an owner bit; the other loop sees zeros.
   logic                      brake_mode_ff, brake_mode_in;
   logic                      owner_ff, owner_in;
   logic signed [SPEED_W-1:0] prev_out_ff, prev_out_in;
   logic signed [ERR_W-1:0]   err1_ff, err1_in;
   logic signed [ERR_W-1:0]   err2_ff, err2_in;

   logic                      idle;
   logic                      own;
   logic signed [ERR_W-1:0]   diff_mt;
   logic signed [ERR_W-1:0]   err;
   logic signed [ERR_W-1:0]   e1;
   logic signed [ERR_W-1:0]   e2;
   logic signed [SPEED_W-1:0] po;
   logic signed [D1_W-1:0]    d1;
   logic signed [D2_W-1:0]    d2;
   logic                      kd_en;
   logic [GAIN_W-1:0]         kp, ki, kd;
   logic [MAX_W-1:0]          max_v, floor_v;
   logic signed [GAIN_W:0]    kp_s, ki_s, kd_s;
   logic signed [GAIN_W+D1_W:0]  p_kp;
   logic signed [GAIN_W+ERR_W:0] p_ki;
   logic signed [GAIN_W+D2_W:0]  p_kd;
   logic signed [ACC_W-1:0]   acc;
   logic signed [SCL_W-1:0]   scaled;
   logic signed [SUM_W-1:0]   sum;
   logic signed [SUM_W-1:0]   max_s, floor_s;
   logic signed [SPEED_W-1:0] out_val;

   // Error of the active loop and its history
   always_comb begin
      idle    = target_i[SPEED_W-1] || (target_i == '0);
      diff_mt = ERR_W'(measured_i) - ERR_W'(target_i);
      err     = brake_mode_ff ? diff_mt : -diff_mt;
      own     = (owner_ff == brake_mode_ff);
      e1      = own ? err1_ff : '0;
      e2      = own ? err2_ff : '0;
      po      = own ? prev_out_ff : '0;
      d1      = D1_W'(err) - D1_W'(e1);
      d2      = D2_W'(err) - (D2_W'(e1) <<< 1) + D2_W'(e2);
      kd_en   = (e1 != '0) && (e2 != '0);
   end

   // Gain set of the active loop
   always_comb begin
      kp      = brake_mode_ff ? cfg_i.brake_kp    : cfg_i.torque_kp;
      ki      = brake_mode_ff ? cfg_i.brake_ki    : cfg_i.torque_ki;
      kd      = brake_mode_ff ? cfg_i.brake_kd    : cfg_i.torque_kd;
      max_v   = brake_mode_ff ? cfg_i.brake_limit : cfg_i.torque_limit;
      floor_v = brake_mode_ff ? BRAKE_FLOOR       : TORQUE_FLOOR;
      kp_s    = $signed({1'b0, kp});
      ki_s    = $signed({1'b0, ki});
      kd_s    = $signed({1'b0, kd});
   end

   // Three products, Q16.16 sum, floor back to Q8.8, add and clamp
   always_comb begin
      p_kp    = kp_s * d1;
      p_ki    = ki_s * err;
      p_kd    = kd_s * d2;
      acc     = ACC_W'(p_kp) + ACC_W'(p_ki) + (kd_en ? ACC_W'(p_kd) : ACC_W'(0));
      scaled  = acc[ACC_W-1:8];
      sum     = SUM_W'(scaled) + SUM_W'(po);
      max_s   = $signed(SUM_W'(max_v));
      floor_s = $signed(SUM_W'(floor_v));
      priority if (sum > max_s) begin
         out_val = SPEED_W'(max_s);
      end else if (sum < floor_s) begin
         out_val = SPEED_W'(floor_s);
      end else begin
         out_val = SPEED_W'(sum);
      end
   end

   // Result of this beat
   always_comb begin
      if (idle) begin
         drive_o   = IDLE_OUT;
         braking_o = 1'b0;
      end else if (brake_mode_ff) begin
         drive_o   = -out_val;
         braking_o = 1'b1;
      end else begin
         drive_o   = out_val;
         braking_o = 1'b0;
      end
   end

   // Next mode and history
   always_comb begin
      brake_mode_in = brake_mode_ff;
      owner_in      = owner_ff;
      prev_out_in   = prev_out_ff;
      err1_in       = err1_ff;
      err2_in       = err2_ff;
      if (step_i) begin
         if (idle) begin
            prev_out_in = '0;
            err1_in     = '0;
            err2_in     = '0;
         end else begin
            owner_in    = brake_mode_ff;
            prev_out_in = out_val;
            err1_in     = err;
            err2_in     = e1;
            if (brake_mode_ff) begin
               brake_mode_in = !diff_mt[ERR_W-1];
            end else begin
               brake_mode_in = (diff_mt > BRAKE_ENTER_MARGIN);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_mode_ff <= 1'b1;
         owner_ff      <= 1'b0;
         prev_out_ff   <= '0;
         err1_ff       <= '0;
         err2_ff       <= '0;
      end else begin
         brake_mode_ff <= brake_mode_in;
         owner_ff      <= owner_in;
         prev_out_ff   <= prev_out_in;
         err1_ff       <= err1_in;
         err2_ff       <= err2_in;
      end
   end

   // An idle target wipes the history and keeps the mode
   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      step_i && idle |=> (prev_out_ff == '0) && (err1_ff == '0) && (err2_ff == '0)
         && (brake_mode_ff == $past(brake_mode_ff)))
      else $error("idle beat did not clear history");

   // History belongs to the loop that just ran
   a_owner: assert property (@(posedge clock) disable iff (reset)
      step_i && !idle |=> owner_ff == $past(brake_mode_ff))
      else $error("history owner not updated");

   // Torque output is never negative
   a_torque_sign: assert property (@(posedge clock) disable iff (reset)
      step_i && !idle && !brake_mode_ff |-> !drive_o[SPEED_W-1])
      else $error("negative torque output");

   // Brake output is never positive
   a_brake_sign: assert property (@(posedge clock) disable iff (reset)
      step_i && !idle && brake_mode_ff |-> drive_o[SPEED_W-1] || (drive_o == '0))
      else $error("positive brake output");

endmodule

// File: design/velocity_pid_torque_brake.sv
// Top level of the velocity controller with torque and brake PID loops.
//
// Each request beat carries a target and a measured speed (signed Q8.8) and
// produces exactly one response beat: a drive value (Q8.8) and a braking flag.
// Positive drive is torque, negative drive is the negated brake output, and a
// target of zero or below gives -50.0 and wipes both loops' history.
// The csr_ channel writes gains and clamps; write it only while no beat is
// in flight. csr_ready is always high.
// The accepting edge loads the input register; the PID result is then loaded
// into the response register when the beat advances, which a stalled receiver
// can hold off. One beat is taken every cycle while the receiver does not
// stall, since the loop history is updated in the same cycle that a beat
// leaves the input register.
// A stalled receiver holds the response register; one more beat may wait in
// the input register, after which req_ready drops until rsp_ready returns.
// Reset restores the register defaults, selects brake mode and clears the
// history of both loops.
module velocity_pid_torque_brake
   import vpt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [SPEED_W-1:0] req_target_speed,
   input  logic signed [SPEED_W-1:0] req_measured_speed,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SPEED_W-1:0] rsp_drive_value,
   output logic                      rsp_braking,
   // configuration channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type                   cfg;
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [SPEED_W-1:0] s1_target_ff;
   logic signed [SPEED_W-1:0] s1_meas_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0] rsp_drive_ff;
   logic                      rsp_braking_ff;
   logic                      advance;
   logic                      req_take;
   logic signed [SPEED_W-1:0] pid_drive;
   logic                      pid_braking;

   vpt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg_o     (cfg)
   );

   vpt_pid u_pid (
      .clock      (clock),
      .reset      (reset),
      .step_i     (advance),
      .target_i   (s1_target_ff),
      .measured_i (s1_meas_ff),
      .cfg_i      (cfg),
      .drive_o    (pid_drive),
      .braking_o  (pid_braking)
   );

   // Stage handshakes
   always_comb begin
      advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready    = !s1_valid_ff || advance;
      req_take     = req_valid && req_ready;
      s1_valid_in  = req_take || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_target_ff <= req_target_speed;
         s1_meas_ff   <= req_measured_speed;
      end
      if (advance) begin
         rsp_drive_ff   <= pid_drive;
         rsp_braking_ff <= pid_braking;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_drive_ff;
   assign rsp_braking     = rsp_braking_ff;

endmodule

// File: tb/tb_velocity_pid_torque_brake.sv
// Self-checking testbench of the velocity controller with torque and brake PID loops.
module tb_velocity_pid_torque_brake;
   import vpt_pkg::*;

   localparam int QUIET_LIMIT = 2000;   // cycles without any beat before giving up
   localparam int SEG_ITEMS   = 50;     // request beats per gain setting in random traffic

   // Loop history as the datapath keeps it
   typedef struct packed {
      logic signed [SPEED_W-1:0] prev_out;
      logic signed [ERR_W-1:0]   err_1;
      logic signed [ERR_W-1:0]   err_2;
   } loop_hist_type;

   // One expected response beat
   typedef struct packed {
      logic signed [SPEED_W-1:0] drive;
      logic                      braking;
   } drive_beat_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [SPEED_W-1:0] req_target_speed = '0;
   logic signed [SPEED_W-1:0] req_measured_speed = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SPEED_W-1:0] rsp_drive_value;
   logic                      rsp_braking;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = REG_TORQUE_KP;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   // Predictor state
   cfg_type        gains;
   logic           brake_mode;
   loop_hist_type  torque_hist;
   loop_hist_type  brake_hist;
   drive_beat_type drive_expected_q[$];

   // Run control and tallies
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int profile_target = 256;
   int quiet_cycles   = 0;
   int error_count    = 0;
   int beats_sent     = 0;
   int gain_loads     = 0;
   int beats_checked  = 0;
   int brake_beats    = 0;
   int idle_beats     = 0;

   velocity_pid_torque_brake i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_target_speed   (req_target_speed),
      .req_measured_speed (req_measured_speed),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_braking        (rsp_braking),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // One incremental PID update: kp on the error step, ki on the error,
   // kd on the second difference once both stored errors are nonzero.
   function automatic logic signed [SPEED_W-1:0] advance_loop(
      inout loop_hist_type           h,
      input logic signed [ERR_W-1:0] err,
      input logic [GAIN_W-1:0]    kp,
      input logic [GAIN_W-1:0]    ki,
      input logic [GAIN_W-1:0]    kd,
      input logic [MAX_W-1:0]     maxv,
      input logic [MAX_W-1:0]     floorv
   );
      longint e0, e1, e2, acc, sum;
      e0  = err;
      e1  = h.err_1;
      e2  = h.err_2;
      acc = longint'(kp) * (e0 - e1) + longint'(ki) * e0;
      if (h.err_1 != 0 && h.err_2 != 0)
         acc += longint'(kd) * (e0 - 2 * e1 + e2);
      // Q16.16 back to Q8.8, rounding towards minus infinity
      sum = (acc >>> 8) + longint'(h.prev_out);
      if (sum > longint'(maxv))
         sum = longint'(maxv);
      else if (sum < longint'(floorv))
         sum = longint'(floorv);
      h.err_2    = h.err_1;
      h.err_1    = err;
      h.prev_out = sum[SPEED_W-1:0];
      return sum[SPEED_W-1:0];
   endfunction

   // Expected response for an accepted request beat; updates mode and history
   function automatic drive_beat_type predict_drive(logic signed [SPEED_W-1:0] target,
                                                    logic signed [SPEED_W-1:0] meas);
      drive_beat_type            beat;
      logic signed [ERR_W-1:0]   over;
      logic signed [SPEED_W-1:0] mag;
      over = meas - target;
      if (target > 0) begin
         if (brake_mode) begin
            // brake loop still runs on the tick that leaves braking
            if (meas < target)
               brake_mode = 1'b0;
            torque_hist  = '0;
            mag          = advance_loop(brake_hist, over, gains.brake_kp, gains.brake_ki,
                                        gains.brake_kd, gains.brake_limit, BRAKE_FLOOR);
            beat.drive   = -mag;
            beat.braking = 1'b1;
         end else begin
            if (over > BRAKE_ENTER_MARGIN)
               brake_mode = 1'b1;
            brake_hist   = '0;
            beat.drive   = advance_loop(torque_hist, -over, gains.torque_kp, gains.torque_ki,
                                        gains.torque_kd, gains.torque_limit, TORQUE_FLOOR);
            beat.braking = 1'b0;
         end
      end else begin
         // idle target wipes both loops, mode kept
         torque_hist  = '0;
         brake_hist   = '0;
         beat.drive   = IDLE_OUT;
         beat.braking = 1'b0;
      end
      return beat;
   endfunction

   // Send one request beat, with random sender idling in front of it
   task automatic send_speeds(logic signed [SPEED_W-1:0] target,
                              logic signed [SPEED_W-1:0] meas);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_target_speed   <= target;
      req_measured_speed <= meas;
      do @(posedge clock); while (!req_ready);
      drive_expected_q.push_back(predict_drive(target, meas));
      beats_sent++;
   endtask

   // Hold off the sender until every response is in
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (drive_expected_q.size() != 0) @(posedge clock);
   endtask

   // Write all eight registers while the block is idle
   task automatic load_gains(input logic [CSR_DATA_W-1:0] vals [8]);
      csr_idx_type idx;
      wait_drained();
      for (int i = 0; i < 8; i++) begin
         idx = csr_idx_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (idx)
            REG_TORQUE_KP:    gains.torque_kp    = vals[i];
            REG_TORQUE_KI:    gains.torque_ki    = vals[i];
            REG_TORQUE_KD:    gains.torque_kd    = vals[i];
            REG_TORQUE_LIMIT: gains.torque_limit = vals[i][MAX_W-1:0];
            REG_BRAKE_KP:     gains.brake_kp     = vals[i];
            REG_BRAKE_KI:     gains.brake_ki     = vals[i];
            REG_BRAKE_KD:     gains.brake_kd     = vals[i];
            REG_BRAKE_LIMIT:  gains.brake_limit  = vals[i][MAX_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
      gain_loads++;
   endtask

   // Gains: zero, full scale, or a moderate value that keeps the loops lively
   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      int roll;
      roll = $urandom_range(99);
      if (roll < 20)
         return '0;
      else if (roll < 40)
         return '1;
      return CSR_DATA_W'($urandom_range(2047));
   endfunction

   // Mostly a target held for a while with the speed hovering round it,
   // crossing both mode thresholds; some full-range noise and idle targets.
   task automatic next_speed_pair(output logic signed [SPEED_W-1:0] target,
                                  output logic signed [SPEED_W-1:0] meas);
      int roll, m;
      roll = $urandom_range(99);
      if (roll < 10) begin
         target = SPEED_W'($urandom);
         meas   = SPEED_W'($urandom);
      end else if (roll < 15) begin
         target = SPEED_W'(0 - int'($urandom_range(32768)));
         meas   = SPEED_W'($urandom);
      end else begin
         if ($urandom_range(99) < 10)
            profile_target = $urandom_range(1, 32767);
         m = profile_target + int'($urandom_range(120)) - 60;
         if (m > 32767)
            m = 32767;
         target = SPEED_W'(profile_target);
         meas   = SPEED_W'(m);
      end
   endtask

   // Idle targets, both mode changes at their thresholds and the speed extremes
   task automatic test_idle_and_modes();
      send_speeds(16'sd0, 16'sd100);
      send_speeds(-16'sd32768, 16'sd32767);
      send_speeds(-16'sd1, -16'sd32768);
      send_speeds(16'sd256, 16'sd300);       // braking from reset
      send_speeds(16'sd256, 16'sd200);       // speed below target: leave braking
      send_speeds(16'sd256, 16'sd100);
      send_speeds(16'sd256, 16'sd281);       // 25 LSB over: stay on torque
      send_speeds(16'sd256, 16'sd282);       // 26 LSB over: enter braking
      send_speeds(16'sd256, 16'sd300);
      send_speeds(16'sd256, 16'sd255);
      send_speeds(16'sd32767, -16'sd32768);  // largest torque error, clamps at max
      send_speeds(16'sd1, 16'sd32767);       // largest overspeed
      send_speeds(16'sd32767, 16'sd32767);   // equal speeds keep braking
      send_speeds(16'sd1, -16'sd32768);
      send_speeds(16'sd32767, -16'sd32768);
      send_speeds(16'sd0, 16'sd0);
   endtask

   // Full-scale gains with the derivative term active, then clamps of zero
   task automatic test_gain_extremes();
      logic [CSR_DATA_W-1:0] vals [8];
      vals = '{default: 16'hFFFF};
      load_gains(vals);
      send_speeds(16'sd100, 16'sd0);
      send_speeds(16'sd100, 16'sd0);
      send_speeds(16'sd100, 16'sd50);
      send_speeds(16'sd100, 16'sd90);
      send_speeds(16'sd100, 16'sd130);
      send_speeds(16'sd100, 16'sd140);
      // torque limit of zero, brake limit written with only the dropped top bit set
      vals = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
               16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000};
      load_gains(vals);
      send_speeds(16'sd100, 16'sd200);
      send_speeds(16'sd100, 16'sd0);
      send_speeds(16'sd100, 16'sd0);
   endtask

   // Random traffic under one idling mix, three gain settings
   task automatic test_random_traffic(int send_pct, int recv_pct);
      logic [CSR_DATA_W-1:0]     vals [8];
      logic signed [SPEED_W-1:0] target, meas;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int seg = 0; seg < 3; seg++) begin
         foreach (vals[i])
            vals[i] = pick_gain();
         vals[REG_TORQUE_LIMIT] = CSR_DATA_W'($urandom);
         vals[REG_BRAKE_LIMIT]  = CSR_DATA_W'($urandom);
         load_gains(vals);
         for (int n = 0; n < SEG_ITEMS; n++) begin
            next_speed_pair(target, meas);
            send_speeds(target, meas);
            // one mid-segment pause until the pipe is empty
            if (n == SEG_ITEMS / 2)
               wait_drained();
         end
      end
   endtask

   // Response checker
   always @(posedge clock) begin
      drive_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expected_q.size() == 0) begin
            $display("%0t: response beat with nothing pending, drive %0d braking %0b",
                     $time, rsp_drive_value, rsp_braking);
            error_count++;
         end else begin
            want = drive_expected_q.pop_front();
            beats_checked++;
            if (want.braking)
               brake_beats++;
            else if (want.drive == IDLE_OUT)
               idle_beats++;
            if (rsp_drive_value !== want.drive) begin
               $display("%0t: drive_value expected %0d, got %0d",
                        $time, want.drive, rsp_drive_value);
               error_count++;
            end
            if (rsp_braking !== want.braking) begin
               $display("%0t: braking expected %0b, got %0b",
                        $time, want.braking, rsp_braking);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles where no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat for %0d cycles, %0d responses outstanding",
                  $time, quiet_cycles, drive_expected_q.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sequence
   initial begin
      gains = '{torque_kp: KP_RESET, torque_ki: KI_RESET, torque_kd: KD_RESET,
                torque_limit: MAX_RESET, brake_kp: KP_RESET, brake_ki: KI_RESET,
                brake_kd: KD_RESET, brake_limit: MAX_RESET};
      brake_mode  = 1'b1;
      torque_hist = '0;
      brake_hist  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_modes();
      test_gain_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(77, 0);
      test_random_traffic(0, 77);
      test_random_traffic(10, 10);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d request beats over %0d gain settings and four idling mixes",
               beats_sent, gain_loads);
      $display("Checked %0d responses: %0d braking, %0d idle, %0d torque",
               beats_checked, brake_beats, idle_beats,
               beats_checked - brake_beats - idle_beats);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
